[rtl/core/imrl_pkg.sv]
package imrl_pkg;

    // default record store depth
    localparam int DEPTH_DEF = 256;

    localparam int CAP_W  = 9;
    localparam int CNT_W  = 9;
    localparam int POS_W  = 9;
    localparam int REC_W  = 21;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // apb register map
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic CFG_IDX_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic load_req;
        logic decode;
        logic shift;
        logic write_rec;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic ok;
        logic shift_needed;
        logic more;
        logic out_free;
    } ctl_stat_t;

endpackage

[rtl/core/imrl_datapath.sv]
module imrl_datapath #(
    parameter int DEPTH = imrl_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [imrl_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [imrl_pkg::OP_W-1:0]       s_tuser,
    input  logic                            cap_wr_en,
    input  logic [imrl_pkg::CAP_W-1:0]      cap_wr_data,
    output logic [imrl_pkg::CAP_W-1:0]      capacity,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [imrl_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [imrl_pkg::STAT_W-1:0]     m_tuser,
    input  imrl_pkg::ctl_cmd_t              cmd,
    output imrl_pkg::ctl_stat_t             stat
);
    import imrl_pkg::*;

    localparam int AW        = $clog2(DEPTH);
    localparam int CAP_LIM_I = (DEPTH > 511) ? 511 : DEPTH;
    localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CAP_LIM_I);

    // record store
    logic [REC_W-1:0] mem [DEPTH];

    op_t              op_reg;
    logic [POS_W-1:0] pos_reg;
    logic [REC_W-1:0] rec_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CAP_W-1:0] cap_reg;
    logic [POS_W-1:0] ptr_reg;
    logic             pend_valid_reg;
    logic [AW-1:0]    pend_addr_reg;
    logic [REC_W-1:0] rd_data_reg;
    logic             m_valid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    status_t          m_tuser_reg;

    logic [CNT_W-1:0] cap_eff;
    status_t          status_code;
    logic             ok;
    logic             shift_needed;
    logic             more;
    logic [POS_W-1:0] src_idx;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [REC_W-1:0] wr_data;
    logic [REC_W-1:0] rec_out;
    logic             out_free;

    assign cap_eff = (cap_reg > CAP_LIM) ? CAP_LIM : cap_reg;

    always_comb begin
        status_code = ST_OK;
        unique case (op_reg)
            OP_READ: begin
                if (pos_reg >= count_reg) status_code = ST_INVALID;
            end
            OP_INSERT: begin
                if (pos_reg > count_reg)       status_code = ST_INVALID;
                else if (count_reg >= cap_eff) status_code = ST_FULL;
            end
            OP_REMOVE: begin
                if (count_reg == '0)            status_code = ST_EMPTY;
                else if (pos_reg >= count_reg) status_code = ST_INVALID;
            end
            default: status_code = ST_OK;
        endcase
    end

    assign ok = (status_code == ST_OK);

    always_comb begin
        shift_needed = 1'b0;
        more         = 1'b0;
        src_idx      = ptr_reg + 1'b1;
        if (op_reg == OP_INSERT) begin
            shift_needed = (pos_reg < count_reg);
            more         = (ptr_reg > pos_reg);
            src_idx      = ptr_reg - 1'b1;
        end else if (op_reg == OP_REMOVE) begin
            shift_needed = ({1'b0, pos_reg} + 10'd1) < {1'b0, count_reg};
            more         = ({1'b0, ptr_reg} + 10'd1) < {1'b0, count_reg};
        end
    end

    // one read and one write per cycle
    assign rd_en   = (cmd.decode && op_reg == OP_READ && ok) || (cmd.shift && more);
    assign rd_addr = cmd.decode ? AW'(pos_reg) : AW'(src_idx);
    assign wr_en   = (cmd.shift && pend_valid_reg) || cmd.write_rec;
    assign wr_addr = cmd.write_rec ? AW'(pos_reg) : pend_addr_reg;
    assign wr_data = cmd.write_rec ? rec_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ok) begin
            case (op_reg)
                OP_INSERT: count_next = count_reg + 1'b1;
                OP_REMOVE: count_next = count_reg - 1'b1;
                OP_CLEAR:  count_next = '0;
                default:   count_next = count_reg;
            endcase
        end
    end

    assign rec_out  = (op_reg == OP_READ && ok) ? rd_data_reg : '0;
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            cap_reg        <= CAP_RESET;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cap_wr_en) begin
                cap_reg <= cap_wr_data;
            end
            if (cmd.commit) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.decode) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.shift) begin
                pend_valid_reg <= more;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg  <= op_t'(s_tuser);
            pos_reg <= s_tdata[POS_W-1:0];
            rec_reg <= s_tdata[POS_W+REC_W-1:POS_W];
        end
        if (cmd.decode) begin
            ptr_reg <= (op_reg == OP_INSERT) ? count_reg : pos_reg;
        end else if (cmd.shift && more) begin
            ptr_reg       <= src_idx;
            pend_addr_reg <= AW'(ptr_reg);
        end
        if (cmd.commit) begin
            m_tdata_reg <= {rec_out, (count_next == '0), (count_next >= cap_eff), count_next};
            m_tuser_reg <= status_code;
        end
    end

    assign capacity = cap_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign stat.op           = op_reg;
    assign stat.ok           = ok;
    assign stat.shift_needed = shift_needed;
    assign stat.more         = more;
    assign stat.out_free     = out_free;

endmodule

[rtl/core/imrl_ctrl.sv]
module imrl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output imrl_pkg::ctl_cmd_t  cmd,
    input  imrl_pkg::ctl_stat_t stat
);
    import imrl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_WRITE  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                if (stat.ok && stat.shift_needed) begin
                    state_next = S_SHIFT;
                end else if (stat.ok && stat.op == OP_INSERT) begin
                    state_next = S_WRITE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (!stat.more) begin
                    state_next = (stat.op == OP_INSERT) ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                cmd.write_rec = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/indexed_move_record_list.sv]
// sequence: read, clear, any failed request and a remove of the last record go from accept
// through decode to the result; an append adds a record write, an insert that moves records
// shifts them and then writes the new record, and a remove that moves records shifts them;
// during a shift one record moves per cycle through the store's port pair
// throughput: one request at a time, the next is accepted in the cycle after the result
// is loaded (the result register may still be waiting on m_tready)
// reset: aresetn synchronous active low; clears count, sets capacity to 256, store not cleared
module indexed_move_record_list #(
    parameter int DEPTH = imrl_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // position[8:0], from_row[11:9], from_col[14:12], to_row[17:15], to_col[20:18],
    // check_kind[22:21], captured_type[25:23], captured_color[27:26],
    // castle_kind[29:28], zero[31:30]
    input  logic [imrl_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  logic [imrl_pkg::OP_W-1:0]       s_tuser,

    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // count[8:0], is_full[9], is_empty[10], out_from_row[13:11], out_from_col[16:14],
    // out_to_row[19:17], out_to_col[22:20], out_check_kind[24:23],
    // out_captured_type[27:25], out_captured_color[29:28], out_castle_kind[31:30]
    output logic [imrl_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [imrl_pkg::STAT_W-1:0]     m_tuser,

    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [imrl_pkg::CFG_AW-1:0]     paddr,
    input  logic [imrl_pkg::CFG_DW-1:0]     pwdata,
    output logic [imrl_pkg::CFG_DW-1:0]     prdata,
    output logic                            pready
);
    import imrl_pkg::*;

    ctl_cmd_t         cmd;
    ctl_stat_t        stat;
    logic             cfg_sel_cap;
    logic             cap_wr_en;
    logic [CAP_W-1:0] capacity;

    // register index is the word address; only capacity exists
    assign cfg_sel_cap = (paddr[CFG_AW-1:2] == CFG_IDX_CAPACITY);
    assign pready      = 1'b1;
    assign cap_wr_en   = psel && penable && pwrite && pready && cfg_sel_cap;
    assign prdata      = cfg_sel_cap ? {{(CFG_DW-CAP_W){1'b0}}, capacity} : '0;

    // sequencer: accept, decode, shift records, write new record, deliver result
    imrl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // record store, count and capacity registers, status decode, result register
    imrl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cap_wr_en   (cap_wr_en),
        .cap_wr_data (pwdata[CAP_W-1:0]),
        .capacity    (capacity),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .stat        (stat)
    );

    // one request in flight: after an accept the input side closes
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // a result is only loaded when the output register can take it
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> stat.out_free)
        else $error("result loaded over an undelivered result");

    // empty flag agrees with the reported count
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10] == (m_tdata[8:0] == '0)))
        else $error("empty flag disagrees with count");

    // a failed request returns no record fields
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[31:11] == '0))
        else $error("record fields set on a failed request");

endmodule

[verif/move_list_checker.sv]
module move_list_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [imrl_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [imrl_pkg::OP_W-1:0]         s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [imrl_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic [imrl_pkg::STAT_W-1:0]       m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [imrl_pkg::CFG_AW-1:0]       paddr,
    input  logic [imrl_pkg::CFG_DW-1:0]       pwdata,
    input  logic                              pready,
    output int                                mismatch_count,
    output int                                pending_results,
    output int                                list_length
);
    timeunit 1ns;
    timeprecision 1ps;

    import imrl_pkg::*;

    // stored move, from_row in the lowest bits
    typedef struct packed {
        logic [1:0] castle_kind;
        logic [1:0] captured_color;
        logic [2:0] captured_type;
        logic [1:0] check_kind;
        logic [2:0] to_col;
        logic [2:0] to_row;
        logic [2:0] from_col;
        logic [2:0] from_row;
    } move_rec_t;

    typedef struct {
        status_t          status;
        logic [CNT_W-1:0] count;
        logic             is_full;
        logic             is_empty;
        move_rec_t        rec;
    } list_result_t;

    localparam logic [CFG_AW-1:0] CAPACITY_ADDR = {CFG_IDX_CAPACITY, 2'b00};

    move_rec_t        move_shadow [DEPTH_DEF];
    int unsigned      shadow_len = 0;
    logic [CAP_W-1:0] capacity_reg = CAP_RESET;
    list_result_t     expected_list_results [$];
    int               errors = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 100)
            $display("[%0t] list result mismatch on %s: got %0d, want %0d",
                     $time, what, got, want);
    endtask

    task automatic predict_list_result(input op_t op, input logic [POS_W-1:0] pos,
                                       input move_rec_t rec, output list_result_t res);
        int unsigned limit;
        int unsigned idx;
        limit      = (capacity_reg > DEPTH_DEF) ? DEPTH_DEF : capacity_reg;
        res.status = ST_OK;
        res.rec    = '0;
        case (op)
            OP_READ: begin
                if (pos >= shadow_len)
                    res.status = ST_INVALID;
                else
                    res.rec = move_shadow[pos];
            end
            OP_INSERT: begin
                if (pos > shadow_len) begin
                    res.status = ST_INVALID;
                end else if (shadow_len >= limit) begin
                    res.status = ST_FULL;
                end else begin
                    for (idx = shadow_len; idx > pos; idx--)
                        move_shadow[idx] = move_shadow[idx-1];
                    move_shadow[pos] = rec;
                    shadow_len++;
                end
            end
            OP_REMOVE: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= shadow_len) begin
                    res.status = ST_INVALID;
                end else begin
                    for (idx = pos; idx + 1 < shadow_len; idx++)
                        move_shadow[idx] = move_shadow[idx+1];
                    shadow_len--;
                end
            end
            OP_CLEAR: begin
                shadow_len = 0;
            end
        endcase
        res.count    = shadow_len[CNT_W-1:0];
        res.is_full  = (shadow_len >= limit);
        res.is_empty = (shadow_len == 0);
    endtask

    task automatic compare_result(input list_result_t got, input list_result_t want);
        if (got.status !== want.status)     report_mismatch("status", got.status, want.status);
        if (got.count !== want.count)       report_mismatch("count", got.count, want.count);
        if (got.is_full !== want.is_full)   report_mismatch("is_full", got.is_full, want.is_full);
        if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", got.is_empty, want.is_empty);
        if (got.rec.from_row !== want.rec.from_row)
            report_mismatch("out_from_row", got.rec.from_row, want.rec.from_row);
        if (got.rec.from_col !== want.rec.from_col)
            report_mismatch("out_from_col", got.rec.from_col, want.rec.from_col);
        if (got.rec.to_row !== want.rec.to_row)
            report_mismatch("out_to_row", got.rec.to_row, want.rec.to_row);
        if (got.rec.to_col !== want.rec.to_col)
            report_mismatch("out_to_col", got.rec.to_col, want.rec.to_col);
        if (got.rec.check_kind !== want.rec.check_kind)
            report_mismatch("out_check_kind", got.rec.check_kind, want.rec.check_kind);
        if (got.rec.captured_type !== want.rec.captured_type)
            report_mismatch("out_captured_type", got.rec.captured_type,
                            want.rec.captured_type);
        if (got.rec.captured_color !== want.rec.captured_color)
            report_mismatch("out_captured_color", got.rec.captured_color,
                            want.rec.captured_color);
        if (got.rec.castle_kind !== want.rec.castle_kind)
            report_mismatch("out_castle_kind", got.rec.castle_kind, want.rec.castle_kind);
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        list_result_t got;
        if (!aresetn) begin
            shadow_len   = 0;
            capacity_reg = CAP_RESET;
            expected_list_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
                capacity_reg = pwdata[CAP_W-1:0];
            // results first: one leaving now belongs to an earlier request
            if (m_tvalid && m_tready) begin
                got.status   = status_t'(m_tuser);
                got.count    = m_tdata[8:0];
                got.is_full  = m_tdata[9];
                got.is_empty = m_tdata[10];
                got.rec      = move_rec_t'(m_tdata[31:11]);
                if (expected_list_results.size() == 0) begin
                    report_mismatch("result with none pending", got.count, -1);
                end else begin
                    want = expected_list_results.pop_front();
                    compare_result(got, want);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_list_result(op_t'(s_tuser), s_tdata[POS_W-1:0],
                                    move_rec_t'(s_tdata[POS_W +: REC_W]), want);
                expected_list_results.push_back(want);
            end
        end
        mismatch_count  = errors;
        pending_results = expected_list_results.size();
        list_length     = shadow_len;
    end

endmodule

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imrl_pkg::*;

    // receiver hold-off length for the back-pressure stretch
    localparam int LONG_HOLD = 400;
    localparam logic [CFG_AW-1:0] CAPACITY_ADDR = {CFG_IDX_CAPACITY, 2'b00};
    localparam int NUM_PHASES = 10;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // position[8:0], from_row[11:9], from_col[14:12], to_row[17:15], to_col[20:18],
    // check_kind[22:21], captured_type[25:23], captured_color[27:26],
    // castle_kind[29:28], zero[31:30]
    logic [S_TDATA_W-1:0]  s_tdata;
    // operation[1:0]
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // count[8:0], is_full[9], is_empty[10], out_from_row[13:11], out_from_col[16:14],
    // out_to_row[19:17], out_to_col[22:20], out_check_kind[24:23],
    // out_captured_type[27:25], out_captured_color[29:28], out_castle_kind[31:30]
    logic [M_TDATA_W-1:0]  m_tdata;
    // status[1:0]
    logic [STAT_W-1:0]     m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_AW-1:0]     paddr;
    logic [CFG_DW-1:0]     pwdata;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;

    int mismatch_count;
    int pending_results;
    int list_length;

    // set by the stimulus right after an accept, cleared by the receiver
    bit long_hold_req = 0;
    // remaining back-to-back requests in a no-gap burst
    int calm_left = 0;

    indexed_move_record_list DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    move_list_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .list_length     (list_length)
    );

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // idle length: mostly zero or short, now and then long
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)      return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else             return $urandom_range(30, 120);
    endfunction

    // operation mix; fill mode grows the list toward its limit
    function automatic op_t pick_op(input bit fill);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (fill) begin
            if (r < 80)      return OP_INSERT;
            else if (r < 92) return OP_READ;
            else             return OP_REMOVE;
        end
        if (r < 35)      return OP_INSERT;
        else if (r < 65) return OP_READ;
        else if (r < 97) return OP_REMOVE;
        else             return OP_CLEAR;
    endfunction

    // position mostly in range, with edges and wild values mixed in
    function automatic logic [POS_W-1:0] pick_position(input int len);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)      return POS_W'($urandom_range(0, len));
        else if (r < 80) return POS_W'(len);
        else if (r < 88) return POS_W'((len == 0) ? 0 : len - 1);
        else if (r < 97) return POS_W'($urandom_range(0, 511));
        else             return ($urandom_range(0, 1) != 0) ? 9'd256 : 9'd511;
    endfunction

    // random gap before a request, skipped inside a burst
    task automatic sender_gap();
        int gap;
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(10, 40);
        gap = (calm_left > 0) ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // called at a falling edge; returns at the accepting rising edge
    task automatic drive_request(input op_t op, input logic [POS_W-1:0] pos,
                                 input logic [REC_W-1:0] rec);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {2'b00, rec, pos};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic offer_move(input op_t op, input logic [POS_W-1:0] pos,
                              input logic [REC_W-1:0] rec);
        sender_gap();
        @(negedge aclk);
        drive_request(op, pos, rec);
    endtask

    // position is chosen from the list length after every earlier request
    task automatic offer_random_move(input bit fill);
        op_t op;
        sender_gap();
        @(negedge aclk);
        op = pick_op(fill);
        drive_request(op, pick_position(list_length), REC_W'($urandom()));
    endtask

    // sender stops until every result is back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    // apb setup then access, only with the block idle
    task automatic write_capacity(input int unsigned value);
        drain_results();
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CAPACITY_ADDR;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // receiver: random stalls, ready runs, and one long hold-off on demand
    initial begin
        int seg_left;
        m_tready = 1'b0;
        seg_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
                m_tready = 1'b1;
            end else if (seg_left > 0) begin
                seg_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready = 1'b1;
                seg_left = $urandom_range(20, 200);
            end else begin
                m_tready = 1'($urandom_range(0, 1));
                seg_left = idle_len();
            end
        end
    end

    // stimulus
    initial begin
        int unsigned phase_cap [NUM_PHASES];
        int          phase_items [NUM_PHASES];
        bit          phase_fill [NUM_PHASES];
        logic [REC_W-1:0] rec_ones;

        phase_cap   = '{256, 300, 100, 1, 0, 5, 511, 17, 2, 256};
        phase_items = '{450, 150, 120, 150, 100, 200, 250, 200, 120, 110};
        phase_fill  = '{1, 0, 0, 0, 0, 0, 1, 0, 0, 0};
        rec_ones    = '1;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_READ;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // empty list: read answers invalid, remove answers empty first
        offer_move(OP_READ, 0, '0);
        offer_move(OP_REMOVE, 0, '0);
        offer_move(OP_REMOVE, 511, '0);
        // insert past the end is invalid
        offer_move(OP_INSERT, 1, '0);
        // all-ones then all-zeros record at the head, then append, middle and one past the end
        offer_move(OP_INSERT, 0, rec_ones);
        offer_move(OP_INSERT, 0, '0);
        offer_move(OP_INSERT, 2, REC_W'($urandom()));
        offer_move(OP_INSERT, 1, REC_W'($urandom()));
        offer_move(OP_INSERT, 5, REC_W'($urandom()));
        // reads at both ends and beyond
        offer_move(OP_READ, 0, '0);
        offer_move(OP_READ, 3, '0);
        offer_move(OP_READ, 4, '0);
        offer_move(OP_READ, 511, '0);
        // remove at count is invalid, then middle and last
        offer_move(OP_REMOVE, 4, '0);
        offer_move(OP_REMOVE, 1, '0);
        offer_move(OP_REMOVE, 2, '0);
        offer_move(OP_READ, 1, '0);
        offer_move(OP_CLEAR, 0, '0);
        offer_move(OP_READ, 0, '0);

        // tiny capacity: full after two, index check wins over full
        write_capacity(2);
        offer_move(OP_INSERT, 0, REC_W'($urandom()));
        offer_move(OP_INSERT, 1, REC_W'($urandom()));
        offer_move(OP_INSERT, 0, REC_W'($urandom()));
        offer_move(OP_INSERT, 3, REC_W'($urandom()));
        // zero capacity: always full
        write_capacity(0);
        offer_move(OP_INSERT, 0, REC_W'($urandom()));
        // capacity below count: nothing lost, still full
        write_capacity(1);
        offer_move(OP_INSERT, 2, REC_W'($urandom()));
        offer_move(OP_REMOVE, 0, '0);
        offer_move(OP_REMOVE, 0, '0);

        // random phases across the capacity range
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(phase_cap[p]);
            for (int i = 0; i < phase_items[p]; i++) begin
                offer_random_move(phase_fill[p]);
                // long receiver hold-off while requests keep coming
                if ((p == 0 && i == 100) || (p == 5 && i == 50))
                    long_hold_req = 1'b1;
                // mid-phase pause until the pipe is empty
                if (i == phase_items[p] / 2)
                    drain_results();
            end
        end

        drain_results();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[indexed_move_record_list.f]
rtl/core/imrl_pkg.sv
rtl/core/imrl_datapath.sv
rtl/core/imrl_ctrl.sv
rtl/core/indexed_move_record_list.sv
verif/move_list_checker.sv
verif/tb_top.sv
